// ===== sv/chte_pkg.sv =====
// ----------------------------------------------------------------------------
// chte_pkg
// shared types and constants of the chained hash table engine
// ----------------------------------------------------------------------------
package chte_pkg;
  localparam int unsigned BUCKETS = 64;
  localparam int unsigned POOL_ENTRIES = 256;
  localparam int unsigned BKT_W = $clog2(BUCKETS);
  localparam int unsigned NODE_W = $clog2(POOL_ENTRIES);
  localparam int unsigned PTR_W = NODE_W + 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_LOOKUP_H = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic we;
    logic [NODE_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } link_wr_t;
endpackage

// ===== sv/chte_link_ram.sv =====
// ----------------------------------------------------------------------------
// chte_link_ram
// node link memory, one write and one registered read per cycle;
// init sweep links the pool as a free list after reset
// ----------------------------------------------------------------------------
module chte_link_ram
  import chte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  link_wr_t wr,
  input  logic [NODE_W-1:0] rd_addr,
  output logic [PTR_W-1:0] rd_data,
  output logic init_busy
);
  logic [PTR_W-1:0] mem [POOL_ENTRIES];
  logic [PTR_W-1:0] init_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_ptr <= '0;
    end else if (init_busy) begin
      init_ptr <= init_ptr + 1'b1;
    end
  end

  assign init_busy = (init_ptr != NIL);

  always_ff @(posedge clk) begin
    if (init_busy) begin
      mem[init_ptr[NODE_W-1:0]] <= init_ptr + 1'b1;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/chte_ctrl.sv =====
// ----------------------------------------------------------------------------
// chte_ctrl
// request sequencer: walks chains one node per memory read, owns the
// bucket heads, key and handle memories, free head and entry count
// ----------------------------------------------------------------------------
module chte_ctrl
  import chte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] req_type,
  input  logic [31:0] full_key,
  input  logic [31:0] entry_handle,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [31:0] found_handle,
  output logic [8:0] entry_total,
  output link_wr_t link_wr,
  output logic [NODE_W-1:0] link_rd_addr,
  input  logic [PTR_W-1:0] link_rd_data,
  input  logic init_busy
);
  typedef enum logic [2:0] {
    S_IDLE, S_HEAD, S_READ, S_CHECK, S_UNLINK, S_DONE
  } state_t;

  state_t state;
  logic [31:0] key_mem [POOL_ENTRIES];
  logic [31:0] hdl_mem [POOL_ENTRIES];
  logic [PTR_W-1:0] head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld;
  logic [PTR_W-1:0] head_rd, free_head, cur, prev, nxt;
  logic [8:0] count;
  logic [1:0] kind;
  logic [31:0] key, hdl, k_rd, h_rd;
  logic [BKT_W-1:0] bkt;
  logic [BKT_W-1:0] head_addr;
  logic hit;

  assign in_stall = (state != S_IDLE) || init_busy;
  assign out_valid = (state == S_DONE);
  assign entry_total = count;
  assign hit = (k_rd == key) && ((kind == REQ_LOOKUP) || (h_rd == hdl));
  // head read is addressed by the incoming key while idle
  assign head_addr = (state == S_IDLE) ? full_key[BKT_W-1:0] : bkt;

  always_ff @(posedge clk) begin
    head_rd <= head_vld[head_addr] ? head_mem[head_addr] : NIL;
    k_rd <= key_mem[cur[NODE_W-1:0]];
    h_rd <= hdl_mem[cur[NODE_W-1:0]];
    if (state == S_HEAD && kind == REQ_INSERT && free_head != NIL) begin
      key_mem[free_head[NODE_W-1:0]] <= key;
      hdl_mem[free_head[NODE_W-1:0]] <= hdl;
    end
  end

  always_comb begin
    link_wr = '0;
    link_rd_addr = cur[NODE_W-1:0];
    if (state == S_IDLE) link_rd_addr = free_head[NODE_W-1:0];
    unique case (state)
      S_HEAD: if (kind == REQ_INSERT && free_head != NIL) begin
        link_wr.we = 1'b1;
        link_wr.addr = free_head[NODE_W-1:0];
        link_wr.data = head_rd;
      end
      S_UNLINK: begin
        link_wr.we = 1'b1;
        link_wr.addr = cur[NODE_W-1:0];
        link_wr.data = free_head;
      end
      S_CHECK: if (hit && kind == REQ_REMOVE && prev != NIL) begin
        link_wr.we = 1'b1;
        link_wr.addr = prev[NODE_W-1:0];
        link_wr.data = link_rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head_vld <= '0;
      free_head <= '0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && !init_busy) begin
          kind <= req_type;
          key <= full_key;
          hdl <= entry_handle;
          bkt <= full_key[BKT_W-1:0];
          found_handle <= '0;
          state <= S_HEAD;
        end
        S_HEAD: begin
          // link_rd_data holds free_head's link here
          if (kind == REQ_INSERT) begin
            if (free_head == NIL) begin
              status <= ST_FULL;
            end else begin
              head_mem[bkt] <= free_head;
              head_vld[bkt] <= 1'b1;
              free_head <= link_rd_data;
              count <= count + 1'b1;
              status <= ST_OK;
            end
            state <= S_DONE;
          end else begin
            cur <= head_rd;
            prev <= NIL;
            if (head_rd == NIL) begin
              status <= ST_MISS;
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (hit) begin
            status <= ST_OK;
            if (kind == REQ_REMOVE) begin
              if (prev == NIL) begin
                head_mem[bkt] <= link_rd_data;
                head_vld[bkt] <= 1'b1;
              end
              state <= S_UNLINK;
            end else begin
              found_handle <= h_rd;
              state <= S_DONE;
            end
          end else if (link_rd_data == NIL) begin
            status <= ST_MISS;
            state <= S_DONE;
          end else begin
            prev <= cur;
            cur <= link_rd_data;
            state <= S_READ;
          end
        end
        S_UNLINK: begin
          free_head <= cur;
          count <= count - 1'b1;
          state <= S_DONE;
        end
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/chained_hash_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// separate chaining hash table over a fixed node pool
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with req_type, full_key, entry_handle.
// output channel: out_valid / out_stall with status, found_handle,
// entry_total; one result word per request word.
// the bucket is the key's low bits; insert pushes at the chain head,
// lookups and remove walk the chain one node per link memory read.
// insert goes idle, head, done; lookup and remove go idle, head, then
// read and check per node visited, remove with an unlink step on a hit.
// the chain walk through the link memory read port sets the rate; one
// request is in flight at a time. after reset the block links the node
// pool as a free list and holds in_stall high meanwhile.
// a result is held on the outputs while out_stall is high; no new request
// is taken until the result is gone.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_top
  import chte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] req_type,
  input  logic [31:0] full_key,
  input  logic [31:0] entry_handle,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [31:0] found_handle,
  output logic [8:0] entry_total
);
  link_wr_t link_wr;
  logic [NODE_W-1:0] link_rd_addr;
  logic [PTR_W-1:0] link_rd_data;
  logic init_busy;

  chte_link_ram u_ram (
    .clk(clk), .rst(rst), .wr(link_wr), .rd_addr(link_rd_addr),
    .rd_data(link_rd_data), .init_busy(init_busy)
  );

  chte_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .full_key(full_key), .entry_handle(entry_handle),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .found_handle(found_handle), .entry_total(entry_total),
    .link_wr(link_wr), .link_rd_addr(link_rd_addr),
    .link_rd_data(link_rd_data), .init_busy(init_busy)
  );
endmodule

// ===== sv/chte_checker.sv =====
// ----------------------------------------------------------------------------
// chte_sva
// port level checks of the hash table engine
// ----------------------------------------------------------------------------
module chte_sva
  import chte_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] status,
  input logic [31:0] found_handle,
  input logic [8:0] entry_total
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(found_handle)) else $error("stalled result changed");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_MISS || status == ST_FULL)
    else $error("bad status");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> found_handle == '0)
    else $error("handle on miss");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_total <= 9'(POOL_ENTRIES)) else $error("count high");
endmodule

bind chained_hash_table_engine_top chte_sva u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .found_handle(found_handle), .entry_total(entry_total)
);
